// ===== src/assert_macros.svh =====
// Assertion macros shared by the token bucket RTL.
// Depends on nothing; users must provide i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/tctb_pkg.sv =====
// Types, constants and register codes for the per-client token bucket.
// Depends on nothing; used by tctb_calc and the top level.
`default_nettype none
package tctb_pkg;

    localparam int CLIENTS  = 64;
    localparam int CLIENT_W = 6;
    localparam int CLI_AW   = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int ADDR_W   = 4;

    localparam logic [15:0] LIMIT_RST = 16'd128;
    localparam logic [19:0] TOL_RST   = 20'd5000;
    localparam logic [15:0] THR_RST   = 16'd30;
    localparam logic [31:0] COOL_RST  = 32'd1920;
    localparam logic [15:0] DET_MAX   = 16'hFFFF;
    localparam logic [CLIENT_W:0] CLIENTS_V = (CLIENT_W + 1)'(CLIENTS);

    typedef enum logic {
        CMD_REFILL  = 1'b0,
        CMD_REQUEST = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        REG_LIMIT = 2'd0,
        REG_TOL   = 2'd1,
        REG_THR   = 2'd2,
        REG_COOL  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] limit;
        logic [19:0] tol;
        logic [15:0] thr;
        logic [31:0] cool;
    } t_cfg;

    typedef struct packed {
        t_cmd                cmd;
        logic [CLIENT_W-1:0] client;
        logic [31:0]         now;
        logic [19:0]         lat;
    } t_item;

    typedef struct packed {
        logic [15:0] tokens;
        logic [15:0] detections;
        logic [31:0] last_report;
        logic [19:0] prev_lat;
        logic [31:0] last_refill;
    } t_entry;

    typedef struct packed {
        logic        allowed;
        logic        report;
        logic [15:0] detect_count;
        logic [15:0] tokens_left;
    } t_res;

    typedef struct packed {
        logic   write;
        t_entry entry;
        t_res   res;
    } t_upd;

endpackage
`default_nettype wire

// ===== src/tctb_calc.sv =====
// Update logic for one client entry: detection count, reporting and bucket.
// Depends on tctb_pkg.
`default_nettype none
module tctb_calc
    import tctb_pkg::*;
(
    input  t_cfg   i_cfg,
    input  t_item  i_item,
    input  t_entry i_entry,
    output t_upd   o_upd
);

    logic        s_in_range;
    logic [19:0] s_diff;
    logic        s_near;
    logic [15:0] s_det_up;
    logic [32:0] s_cool_end;
    logic        s_cool_ok;
    logic [31:0] s_elapsed;
    logic [32:0] s_sum;
    t_entry      s_new;
    t_res        s_res;

    always_comb begin
        s_in_range = {1'b0, i_item.client} < CLIENTS_V;
        s_diff     = (i_entry.prev_lat >= i_item.lat) ? (i_entry.prev_lat - i_item.lat)
                                                      : (i_item.lat - i_entry.prev_lat);
        s_near     = s_diff <= i_cfg.tol;
        s_det_up   = (i_entry.detections == DET_MAX) ? i_entry.detections
                                                      : i_entry.detections + 16'd1;
        s_cool_end = {1'b0, i_entry.last_report} + {1'b0, i_cfg.cool};
        s_cool_ok  = {1'b0, i_item.now} > s_cool_end;
        s_elapsed  = i_item.now - i_entry.last_refill;
        s_sum      = {1'b0, s_elapsed} + {17'd0, i_entry.tokens};

        s_new = i_entry;
        s_res = '0;
        unique case (i_item.cmd)
            CMD_REFILL: begin
                if (i_entry.tokens == 16'd0 && s_near) begin
                    s_new.detections = s_det_up;
                    if (s_det_up >= i_cfg.thr && s_cool_ok) begin
                        s_new.last_report = i_item.now;
                        s_res.report      = 1'b1;
                    end
                end else if (i_entry.detections != 16'd0) begin
                    s_new.detections = i_entry.detections - 16'd1;
                end
                s_new.tokens      = (s_sum > {17'd0, i_cfg.limit}) ? i_cfg.limit
                                                                   : s_sum[15:0];
                s_new.prev_lat    = i_item.lat;
                s_new.last_refill = i_item.now;
            end
            CMD_REQUEST: begin
                if (i_entry.tokens != 16'd0) begin
                    s_new.tokens  = i_entry.tokens - 16'd1;
                    s_res.allowed = 1'b1;
                end
            end
        endcase
        s_res.detect_count = s_new.detections;
        s_res.tokens_left  = s_new.tokens;

        o_upd.write = s_in_range;
        o_upd.entry = s_new;
        o_upd.res   = s_in_range ? s_res : '0;
    end

endmodule
`default_nettype wire

// ===== src/per_client_tick_token_bucket_top.sv =====
// Top level of the per-client token bucket with abuse detection.
// Depends on tctb_pkg, tctb_calc and assert_macros.svh.
//
// Channel   Signals                                          Beat taken when
// item in   start, i_command, i_client, i_now_tick, ...      start && !busy
// result    o_valid, o_allowed, o_report, o_detect_count...  o_valid (one cycle)
// config    psel, penable, pwrite, paddr, pwdata, prdata     psel && penable && pwrite
//
// An item may be taken in every cycle; it is registered with its entry read, then its
// result is registered. The entry memory is read at the accepting edge and written back
// at the next edge after update logic, with a one-entry bypass for back-to-back items.
// Reset is synchronous and clears per-entry valid bits, so no clearing pass is needed.
// busy is high only during reset; results cannot be stalled.
`default_nettype none
`include "assert_macros.svh"
module per_client_tick_token_bucket_top
    import tctb_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_command,
    input  wire logic [CLIENT_W-1:0] i_client,
    input  wire logic [31:0]         i_now_tick,
    input  wire logic [19:0]         i_latency_us,
    output logic                     o_valid,
    output logic                     o_allowed,
    output logic                     o_report,
    output logic [15:0]              o_detect_count,
    output logic [15:0]              o_tokens_left,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    t_cfg              r_cfg;
    logic              s_acc;
    logic              s_cfg_wr;
    logic [CLI_AW-1:0] s_rd_idx;
    logic [CLI_AW-1:0] s_wr_idx;

    logic              r_p_vld;
    t_item             r_p_item;
    t_entry            r_rd;
    logic              r_rd_vld;
    logic              r_vld [CLIENTS];
    t_entry            r_mem [CLIENTS];

    logic              r_fw_vld;
    logic [CLIENT_W-1:0] r_fw_cli;
    t_entry            r_fw_entry;

    t_entry            s_entry;
    t_upd              s_upd;
    logic              s_wr;
    t_res              r_res;
    logic              r_o_vld;

    assign busy     = ~i_rst_n;
    assign pready   = 1'b1;
    assign s_acc    = start & ~busy;
    assign s_cfg_wr = psel & penable & pwrite & pready;
    assign s_rd_idx = i_client[CLI_AW-1:0];
    assign s_wr_idx = r_p_item.client[CLI_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limit <= LIMIT_RST;
            r_cfg.tol   <= TOL_RST;
            r_cfg.thr   <= THR_RST;
            r_cfg.cool  <= COOL_RST;
        end else if (s_cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_LIMIT: r_cfg.limit <= pwdata[15:0];
                REG_TOL:   r_cfg.tol   <= pwdata[19:0];
                REG_THR:   r_cfg.thr   <= pwdata[15:0];
                REG_COOL:  r_cfg.cool  <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_LIMIT: prdata = {16'd0, r_cfg.limit};
            REG_TOL:   prdata = {12'd0, r_cfg.tol};
            REG_THR:   prdata = {16'd0, r_cfg.thr};
            REG_COOL:  prdata = r_cfg.cool;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_p_item <= '{cmd: t_cmd'(i_command), client: i_client,
                          now: i_now_tick, lat: i_latency_us};
            r_rd     <= r_mem[s_rd_idx];
            r_rd_vld <= r_vld[s_rd_idx];
        end
        if (s_wr) begin
            r_mem[s_wr_idx] <= s_upd.entry;
        end
        r_fw_cli   <= r_p_item.client;
        r_fw_entry <= s_upd.entry;
        r_res      <= s_upd.res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld  <= 1'b0;
            r_fw_vld <= 1'b0;
            r_o_vld  <= 1'b0;
            for (int i = 0; i < CLIENTS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_p_vld  <= s_acc;
            r_fw_vld <= s_wr;
            r_o_vld  <= r_p_vld;
            if (s_wr) begin
                r_vld[s_wr_idx] <= 1'b1;
            end
        end
    end

    always_comb begin
        if (r_fw_vld && r_fw_cli == r_p_item.client) begin
            s_entry = r_fw_entry;
        end else if (r_rd_vld) begin
            s_entry = r_rd;
        end else begin
            s_entry = '0;
        end
    end

    tctb_calc u_calc (
        .i_cfg   (r_cfg),
        .i_item  (r_p_item),
        .i_entry (s_entry),
        .o_upd   (s_upd)
    );

    assign s_wr = r_p_vld & s_upd.write;

    assign o_valid        = r_o_vld;
    assign o_allowed      = r_res.allowed;
    assign o_report       = r_res.report;
    assign o_detect_count = r_res.detect_count;
    assign o_tokens_left  = r_res.tokens_left;

    `ASSERT_NXT(a_result_follows, r_p_vld, o_valid)
    `ASSERT_IMP(a_no_stray_result, o_valid, $past(r_p_vld))
    `ASSERT_IMP(a_allow_report_excl, o_valid, !(o_allowed && o_report))
    `ASSERT_IMP(a_report_has_count, o_valid && o_report, o_detect_count != 16'd0)
    `ASSERT_IMP(a_refill_capped, s_wr && r_p_item.cmd == CMD_REFILL, s_upd.entry.tokens <= r_cfg.limit)

endmodule
`default_nettype wire
